[rtl/core/pidl_pkg.sv]
// Shared types and codes for the positional insert/delete list.
`default_nettype none
package pidl_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int IDX_W  = 6;

    localparam logic [1:0] MODE_TRAVERSE = 2'd0;
    localparam logic [1:0] MODE_INSERT   = 2'd1;
    localparam logic [1:0] MODE_DELETE   = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_RANGE = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] tail;
    } t_cell_cmd;

endpackage
`default_nettype wire

[rtl/core/pidl_cell.sv]
// One list cell: holds an entry and takes it from a neighbour, the input or the head.
`default_nettype none
module pidl_cell #(
    parameter int IDX = 0
) (
    input  wire logic                               i_clk,
    input  wire pidl_pkg::t_cell_cmd                i_cmd,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_value,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_right,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_head,
    output logic signed [pidl_pkg::DATA_W-1:0]      o_entry
);
    import pidl_pkg::*;

    localparam logic [IDX_W-1:0] IDX_V = IDX_W'(IDX);

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (IDX_V == i_cmd.idx) begin
                    n_entry = i_value;
                end else if (IDX_V > i_cmd.idx) begin
                    n_entry = i_left;
                end
            end
            CELL_DELETE: begin
                if (IDX_V >= i_cmd.idx) begin
                    n_entry = i_right;
                end
            end
            CELL_ROTATE: begin
                n_entry = (IDX_V == i_cmd.tail) ? i_head : i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

[rtl/core/positional_insert_delete_list_top.sv]
// Top level of the positional insert/delete list: control and the row of cells.
//
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. i_mode selects traverse, insert or delete; i_position is 1-based;
// i_value is the entry to insert. Mode 3 is taken and ignored.
// Result channel: o_valid marks each result for one cycle; it cannot be held off.
// Insert and delete shift the cells from the position onward in parallel in the
// cycle of acceptance; their single result is registered for the next cycle, and
// a new command may follow at once, so they run at one transaction per cycle.
// Traverse of N entries rotates the row of cells by one place per cycle, with
// busy high throughout; its results then follow at one per cycle, o_last on the
// final one, which is shown in the first cycle with busy low. After N rotations
// the row is back in order. An empty traverse gives one result with status empty
// and does not raise busy.
// Errors (full, empty, position out of range) give one result and change nothing.
// Reset clears the fill count and the controller; entries need no reset as no
// entry is read before it has been written.
`default_nettype none
module positional_insert_delete_list_top #(
    parameter int CAPACITY = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    input  wire logic [1:0]                         i_mode,
    input  wire logic [pidl_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_value,
    output logic                                    busy,
    output logic                                    o_valid,
    output logic signed [pidl_pkg::DATA_W-1:0]      o_data,
    output logic [1:0]                              o_status,
    output logic                                    o_last,
    output logic [5:0]                              o_fill_count
);
    import pidl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_TRAV
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_count;
    logic [IDX_W-1:0]         r_trav;

    logic [6:0]               cnt7;
    logic                     accept;
    logic                     full;
    logic                     ins_ok;
    logic                     del_ok;
    logic                     trav_end;
    t_cell_cmd                cmd;
    logic signed [DATA_W-1:0] w_entry [CAPACITY];

    assign cnt7     = 7'(r_count);
    assign busy     = (r_state == ST_TRAV);
    assign accept   = start && !busy;
    assign full     = (cnt7 >= 7'(CAPACITY));
    assign ins_ok   = (i_position != '0) && (7'(i_position) <= (cnt7 + 7'd1));
    assign del_ok   = (i_position != '0) && (7'(i_position) <= cnt7);
    assign trav_end = (r_trav == cmd.tail);

    always_comb begin
        cmd.op   = CELL_HOLD;
        cmd.idx  = IDX_W'(i_position - POS_W'(1));
        cmd.tail = IDX_W'(cnt7 - 7'd1);
        if (busy) begin
            cmd.op = CELL_ROTATE;
        end else if (accept) begin
            if ((i_mode == MODE_INSERT) && !full && ins_ok) begin
                cmd.op = CELL_INSERT;
            end else if ((i_mode == MODE_DELETE) && (cnt7 != 7'd0) && del_ok) begin
                cmd.op = CELL_DELETE;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        pidl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_entry[0]),
            .o_entry (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_trav  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        o_data       <= '0;
                        o_last       <= 1'b1;
                        o_fill_count <= cnt7[5:0];
                        case (i_mode)
                            MODE_TRAVERSE: begin
                                if (cnt7 == 7'd0) begin
                                    o_valid  <= 1'b1;
                                    o_status <= STATUS_EMPTY;
                                end else begin
                                    r_state <= ST_TRAV;
                                    r_trav  <= '0;
                                end
                            end
                            MODE_INSERT: begin
                                o_valid <= 1'b1;
                                if (full) begin
                                    o_status <= STATUS_FULL;
                                end else if (!ins_ok) begin
                                    o_status <= STATUS_RANGE;
                                end else begin
                                    o_status     <= STATUS_OK;
                                    r_count      <= CW'(cnt7 + 7'd1);
                                    o_fill_count <= 6'(cnt7 + 7'd1);
                                end
                            end
                            MODE_DELETE: begin
                                o_valid <= 1'b1;
                                if (cnt7 == 7'd0) begin
                                    o_status <= STATUS_EMPTY;
                                end else if (!del_ok) begin
                                    o_status <= STATUS_RANGE;
                                end else begin
                                    o_status     <= STATUS_OK;
                                    r_count      <= CW'(cnt7 - 7'd1);
                                    o_fill_count <= 6'(cnt7 - 7'd1);
                                end
                            end
                            default: begin
                                o_valid <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_TRAV: begin
                    o_valid      <= 1'b1;
                    o_data       <= w_entry[0];
                    o_status     <= STATUS_OK;
                    o_last       <= trav_end;
                    o_fill_count <= cnt7[5:0];
                    if (trav_end) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_trav <= r_trav + IDX_W'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/pidl_checker.sv]
// Port-level checks for the positional insert/delete list, bound to the top level.
`default_nettype none
module pidl_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               start,
    input wire logic [1:0]                         i_mode,
    input wire logic                               busy,
    input wire logic                               o_valid,
    input wire logic signed [pidl_pkg::DATA_W-1:0] o_data,
    input wire logic [1:0]                         o_status,
    input wire logic                               o_last
);
    import pidl_pkg::*;

    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy && (i_mode != MODE_UNUSED)) |=> (o_valid || busy))
        else $error("accepted transaction gave no result and no traverse in the next cycle");

    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid && (o_status == STATUS_OK)))
        else $error("traverse stream broken");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final result while not busy");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STATUS_OK)) |-> (o_last && (o_data == '0)))
        else $error("error result not final or data not zero");

endmodule

bind positional_insert_delete_list_top pidl_checker u_pidl_checker (.*);
`default_nettype wire
